### hdl/contiguous_block_bitmap_allocator_unit_macros.svh
// Assertion macros shared by the allocator's checker.
`ifndef CONTIGUOUS_BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define CONTIGUOUS_BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CBBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// The expression must never be true outside reset.
`define CBBA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

### hdl/cbba_pkg.sv
// Shared types, widths and command codes of the bitmap allocator.
package cbba_pkg;

  localparam int CMD_W          = 2;
  localparam int START_W        = 10;
  localparam int CNT_W          = 11;
  localparam int BLOCK_W        = 10;
  localparam int WORD_W         = 8;
  localparam int DEF_NUM_BLOCKS = 1024;

  localparam logic [CMD_W-1:0] CMD_FIND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write a zero word during the clearing pass
    logic load;    // capture a new request
    logic issue;   // read the word at the scan address and step it
    logic emit;    // move the result into the output register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_hi;     // scan address is at the last word of the range
    logic hit;       // the word in process completes a free run (find only)
    logic imm;       // the request being loaded needs no scan
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

### hdl/cbba_datapath.sv
// Datapath of the allocator: bitmap memory, scan address, run tracking, result registers.
module cbba_datapath #(
  parameter int NUM_BLOCKS = cbba_pkg::DEF_NUM_BLOCKS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cbba_pkg::ctl_t               ctl,
  output cbba_pkg::stat_t              st,
  input  logic [cbba_pkg::CMD_W-1:0]   cmd,
  input  logic [cbba_pkg::START_W-1:0] start_req,
  input  logic [cbba_pkg::CNT_W-1:0]   count,
  input  logic                         mark_used,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         ok,
  output logic [cbba_pkg::BLOCK_W-1:0] block
);

  localparam int WORD_W    = cbba_pkg::WORD_W;
  localparam int CNT_W     = cbba_pkg::CNT_W;
  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SEL_W     = $clog2(WORD_W);
  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int XW        = (IDX_W + 1 > CNT_W + 1) ? IDX_W + 1 : CNT_W + 1;

  localparam logic [XW-1:0]   N_X         = XW'(NUM_BLOCKS);
  localparam logic [WA_W-1:0] LAST_WORD   = WA_W'(NUM_WORDS - 1);
  localparam logic [XW-1:0]   LAST_WORD_X = XW'(NUM_WORDS - 1);

  logic [WORD_W-1:0] mem [NUM_WORDS];

  logic [cbba_pkg::CMD_W-1:0] op;
  logic [XW-1:0]     start_x;
  logic [XW-1:0]     end_x;
  logic [CNT_W-1:0]  need;
  logic              set_val;
  logic [WA_W-1:0]   addr;
  logic [WA_W-1:0]   hi;
  logic              rd_v;
  logic [WA_W-1:0]   rd_addr;
  logic [WORD_W-1:0] rdata;
  logic [CNT_W-1:0]  run;
  logic [IDX_W-1:0]  first;
  logic              found;
  logic              res_ok;
  logic [IDX_W-1:0]  res_blk;

  // Request decode at load time.
  logic [XW-1:0]     start_in;
  logic [XW-1:0]     end_in;
  logic [XW-1:0]     last_word_in;
  logic              oor_in;
  logic              imm_in;
  logic              ok_in;
  logic [WA_W-1:0]   lo_in;
  logic [WA_W-1:0]   hi_in;

  always_comb begin
    start_in     = XW'(start_req);
    end_in       = start_in + XW'(count);
    last_word_in = (end_in - XW'(1)) >> SEL_W;
    oor_in       = end_in > N_X;
    imm_in       = (cmd != cbba_pkg::CMD_FIND && cmd != cbba_pkg::CMD_MARK &&
                    cmd != cbba_pkg::CMD_TEST) || (count == '0) ||
                   (cmd != cbba_pkg::CMD_FIND && start_in >= N_X);
    case (cmd)
      cbba_pkg::CMD_FIND: ok_in = 1'b0;
      cbba_pkg::CMD_MARK: ok_in = 1'b1;
      cbba_pkg::CMD_TEST: ok_in = (count == '0) || !oor_in;
      default:            ok_in = 1'b0;
    endcase
    if (cmd == cbba_pkg::CMD_FIND) begin
      lo_in = '0;
      hi_in = LAST_WORD;
    end else begin
      lo_in = WA_W'(start_in >> SEL_W);
      hi_in = (last_word_in > LAST_WORD_X) ? LAST_WORD : WA_W'(last_word_in);
    end
  end

  // Word processing: mark rewrite, test check and the first-fit run walk.
  logic              proc;
  logic [WORD_W-1:0] wr_word;
  logic              bad_w;
  logic              hit_w;
  logic [CNT_W-1:0]  run_w;
  logic [IDX_W-1:0]  first_w;
  logic [IDX_W-1:0]  where_w;

  always_comb begin
    logic [XW-1:0] idx;
    logic          inb;
    logic          inr;
    logic          h;
    wr_word = rdata;
    bad_w   = 1'b0;
    run_w   = run;
    first_w = first;
    where_w = '0;
    h       = 1'b0;
    for (int b = 0; b < WORD_W; b++) begin
      idx = (XW'(rd_addr) << SEL_W) | XW'(b);
      inb = idx < N_X;
      inr = (idx >= start_x) && (idx < end_x);
      if (inb && inr) begin
        wr_word[b] = set_val;
      end
      if (inb && inr && rdata[b]) begin
        bad_w = 1'b1;
      end
      // Blocks beyond the end of the map count as used.
      if (!h) begin
        if (inb && !rdata[b]) begin
          if (run_w == '0) begin
            first_w = IDX_W'(idx);
          end
          run_w = run_w + 1'b1;
          if (run_w == need) begin
            h       = 1'b1;
            where_w = first_w;
          end
        end else begin
          run_w = '0;
        end
      end
    end
    hit_w = h && (op == cbba_pkg::CMD_FIND);
  end

  assign proc = rd_v && !found;

  always_comb begin
    st.at_hi    = addr == hi;
    st.hit      = proc && hit_w;
    st.imm      = imm_in;
    st.out_free = !rsp_valid || rsp_ready;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      hi        <= LAST_WORD;
      rd_v      <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_v <= ctl.issue;
      if (ctl.load) begin
        addr  <= lo_in;
        hi    <= hi_in;
        found <= 1'b0;
      end else if (ctl.clear || ctl.issue) begin
        addr <= addr + 1'b1;
      end
      if (proc && hit_w) begin
        found <= 1'b1;
      end
      if (ctl.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_addr <= addr;
    if (ctl.load) begin
      op      <= cmd;
      start_x <= start_in;
      end_x   <= end_in;
      need    <= count;
      set_val <= mark_used;
      run     <= '0;
      first   <= '0;
      res_ok  <= ok_in;
      res_blk <= '0;
    end else if (proc) begin
      if (op == cbba_pkg::CMD_FIND) begin
        run   <= run_w;
        first <= first_w;
      end
      if (hit_w) begin
        res_ok  <= 1'b1;
        res_blk <= where_w;
      end
      if (op == cbba_pkg::CMD_TEST && bad_w) begin
        res_ok <= 1'b0;
      end
    end
    if (ctl.emit) begin
      ok    <= res_ok;
      block <= cbba_pkg::BLOCK_W'(res_blk);
    end
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      mem[addr] <= '0;
    end else if (proc && op == cbba_pkg::CMD_MARK) begin
      mem[rd_addr] <= wr_word;
    end
    if (ctl.issue) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/cbba_ctrl.sv
// Controller of the allocator: clearing pass, request intake, scan sequencing, result hand-off.
module cbba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output cbba_pkg::ctl_t  ctl,
  input  cbba_pkg::stat_t st
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_TAIL,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    req_ready = state == S_IDLE;
    ctl.clear = state == S_CLEAR;
    ctl.load  = (state == S_IDLE) && req_valid;
    ctl.issue = state == S_ISSUE;
    ctl.emit  = (state == S_RESULT) && st.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (st.at_hi) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = st.imm ? S_RESULT : S_ISSUE;
      end
      S_ISSUE: begin
        // A found run ends the scan, but at the last word the last read must still come back.
        if (st.at_hi) state_next = S_TAIL;
        else if (st.hit) state_next = S_RESULT;
      end
      S_TAIL: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/contiguous_block_bitmap_allocator_unit.sv
// Top level of the first-fit contiguous block bitmap allocator.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+--------------------------------
//  request | req_valid / req_ready | cmd, start_req, count, mark_used
//  result  | rsp_valid / rsp_ready | ok, block
//
// The bitmap is held as 8-bit words in one memory and is scanned one word at a time.
// Find scans the whole map word by word and stops early when a run is found.
// Mark and test scan only the words the range covers.
// Zero count, unknown command, or a mark or test range starting past the end needs no scan.
// After reset a clearing pass over every word of the bitmap runs with req_ready low.
// A result waiting in the output register does not stop the next request being taken.
module contiguous_block_bitmap_allocator_unit #(
  parameter int NUM_BLOCKS = cbba_pkg::DEF_NUM_BLOCKS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [cbba_pkg::CMD_W-1:0]   cmd,
  input  logic [cbba_pkg::START_W-1:0] start_req,
  input  logic [cbba_pkg::CNT_W-1:0]   count,
  input  logic                         mark_used,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         ok,
  output logic [cbba_pkg::BLOCK_W-1:0] block
);

  cbba_pkg::ctl_t  ctl;
  cbba_pkg::stat_t st;

  cbba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .ctl       (ctl),
    .st        (st)
  );

  cbba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .st        (st),
    .cmd       (cmd),
    .start_req (start_req),
    .count     (count),
    .mark_used (mark_used),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ok        (ok),
    .block     (block)
  );

endmodule

### hdl/cbba_checker.sv
// Port-level checker for the allocator and its bind to the top level.
`include "contiguous_block_bitmap_allocator_unit_macros.svh"

module cbba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         ok,
  input logic [cbba_pkg::BLOCK_W-1:0] block
);

  `CBBA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(block), "result changed while stalled")
  `CBBA_NEVER(a_miss_block, rsp_valid && !ok && (block != '0), "failed result carries a block number")
  `CBBA_ASSERT(a_clear_pass, $past(rst) |-> !req_ready, "request taken before the bitmap was cleared")
  `CBBA_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready, "second request taken straight after a transfer")

endmodule

bind contiguous_block_bitmap_allocator_unit cbba_checker u_cbba_checker (.*);
